// ----- rtl/csvlfs_pkg.sv -----
// Shared definitions for the CSV line field splitter.
// Holds the character constants, the result entry type and the tuser bit positions.
// No dependencies.
package csvlfs_pkg;

  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharComma = 8'h2C;

  // Bit positions of the result flags in m_axis_tuser_o.
  localparam int unsigned UserCharValid = 0;
  localparam int unsigned UserFieldEnd  = 1;
  localparam int unsigned UserLineEnd   = 2;
  localparam int unsigned UserWidth     = 3;

  // Default depth of the result queue; it must hold at least two entries.
  localparam int unsigned ResQueueDepth = 4;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       field_end;
    logic       line_end;
    logic       run_last;
  } result_t;

endpackage

// ----- rtl/csv_line_field_splitter_unit.sv -----
// Top level of the CSV line field splitter; depends on csvlfs_pkg.
// A character passes through the input register and the result queue before its first
// result is offered. Throughput: one character per cycle while the queue has room for two
// results; a character with two results takes two output transfers.
// Reset (rst_ni low, asynchronous) empties the input register and the result queue
// and returns the parser to the field start state.
module csv_line_field_splitter_unit #(
  parameter int unsigned QueueDepth = csvlfs_pkg::ResQueueDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [7:0]                       s_axis_tdata_i,   // [7:0] char_in
  input  logic                             s_axis_tlast_i,   // line_last
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [7:0]                       m_axis_tdata_o,   // [7:0] out_char
  output logic [csvlfs_pkg::UserWidth-1:0] m_axis_tuser_o,   // [0] char_valid,
                                                             // [1] field_end, [2] line_end
  output logic                             m_axis_tlast_o    // run_last
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  localparam logic [1:0] ModeStart  = 2'd0;
  localparam logic [1:0] ModePlain  = 2'd1;
  localparam logic [1:0] ModeQuoted = 2'd2;
  localparam logic [1:0] ModeQseen  = 2'd3;

  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_last_q;
  logic [1:0] mode_q, mode_d;

  csvlfs_pkg::result_t queue_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  csvlfs_pkg::result_t res0, res1, chr_res, mark_res, line_res;
  logic [1:0] res_n;
  logic       proc, pop, is_quote, is_comma;
  logic       emit_chr, emit_mark;

  // Advances a queue pointer by k entries with wraparound.
  function automatic logic [PtrW-1:0] ptr_add(logic [PtrW-1:0] ptr, logic [1:0] k);
    logic [CntW-1:0] sum;
    sum = CntW'(ptr) + CntW'(k);
    if (sum >= CntW'(QueueDepth)) begin
      sum = sum - CntW'(QueueDepth);
    end
    return PtrW'(sum);
  endfunction

  // The held character is parsed once the queue has room for two results.
  assign proc            = in_valid_q && (count_q <= CntW'(QueueDepth - 2));
  assign s_axis_tready_o = !in_valid_q || proc;
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;

  assign is_quote = (in_char_q == csvlfs_pkg::CharQuote);
  assign is_comma = (in_char_q == csvlfs_pkg::CharComma);

  always_comb begin
    emit_chr  = 1'b0;
    emit_mark = 1'b0;
    mode_d    = mode_q;
    case (mode_q)
      ModeQuoted: begin
        if (is_quote) begin
          mode_d = ModeQseen;
        end else begin
          emit_chr = 1'b1;
          mode_d   = ModeQuoted;
        end
      end
      ModeStart: begin
        if (is_quote) begin
          mode_d = ModeQuoted;
        end else if (is_comma) begin
          emit_mark = 1'b1;
          mode_d    = ModeStart;
        end else begin
          emit_chr = 1'b1;
          mode_d   = ModePlain;
        end
      end
      ModeQseen: begin
        if (is_quote) begin
          emit_chr = 1'b1;
          mode_d   = ModeQuoted;
        end else if (is_comma) begin
          emit_mark = 1'b1;
          mode_d    = ModeStart;
        end else begin
          emit_chr = 1'b1;
          mode_d   = ModePlain;
        end
      end
      default: begin
        if (is_comma) begin
          emit_mark = 1'b1;
          mode_d    = ModeStart;
        end else begin
          emit_chr = 1'b1;
          mode_d   = ModePlain;
        end
      end
    endcase
    if (in_last_q) begin
      mode_d = ModeStart;
    end
  end

  always_comb begin
    chr_res  = '{out_char: in_char_q, char_valid: 1'b1, field_end: 1'b0,
                 line_end: 1'b0, run_last: !in_last_q};
    mark_res = '{out_char: 8'h00, char_valid: 1'b0, field_end: 1'b1,
                 line_end: 1'b0, run_last: !in_last_q};
    line_res = '{out_char: 8'h00, char_valid: 1'b0, field_end: 1'b1,
                 line_end: 1'b1, run_last: 1'b1};
    res1 = line_res;
    if (emit_chr) begin
      res0  = chr_res;
      res_n = in_last_q ? 2'd2 : 2'd1;
    end else if (emit_mark) begin
      res0  = mark_res;
      res_n = in_last_q ? 2'd2 : 2'd1;
    end else begin
      res0  = line_res;
      res_n = in_last_q ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      mode_q     <= ModeStart;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      count_q    <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (proc) begin
        mode_q <= mode_d;
      end
      if (proc) begin
        wr_ptr_q <= ptr_add(wr_ptr_q, res_n);
      end
      if (pop) begin
        rd_ptr_q <= ptr_add(rd_ptr_q, 2'd1);
      end
      count_q <= count_q + (proc ? CntW'(res_n) : CntW'(0)) - (pop ? CntW'(1) : CntW'(0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    if (proc && (res_n != 2'd0)) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (proc && (res_n == 2'd2)) begin
      queue_q[ptr_add(wr_ptr_q, 2'd1)] <= res1;
    end
  end

  assign m_axis_tvalid_o = (count_q != '0);
  assign m_axis_tdata_o  = queue_q[rd_ptr_q].out_char;
  assign m_axis_tlast_o  = queue_q[rd_ptr_q].run_last;
  always_comb begin
    m_axis_tuser_o                            = '0;
    m_axis_tuser_o[csvlfs_pkg::UserCharValid] = queue_q[rd_ptr_q].char_valid;
    m_axis_tuser_o[csvlfs_pkg::UserFieldEnd]  = queue_q[rd_ptr_q].field_end;
    m_axis_tuser_o[csvlfs_pkg::UserLineEnd]   = queue_q[rd_ptr_q].line_end;
  end

endmodule

// ----- rtl/csvlfs_checker.sv -----
// Port-level checks for the CSV line field splitter, bound to its top level.
// Depends on csvlfs_pkg and csv_line_field_splitter_unit.
module csvlfs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [7:0]                       m_axis_tdata_o,
  input logic [csvlfs_pkg::UserWidth-1:0] m_axis_tuser_o,
  input logic                             m_axis_tlast_o
);

  logic cv, fe, le;
  assign cv = m_axis_tuser_o[csvlfs_pkg::UserCharValid];
  assign fe = m_axis_tuser_o[csvlfs_pkg::UserFieldEnd];
  assign le = m_axis_tuser_o[csvlfs_pkg::UserLineEnd];

  // A result is either a character or a field marker, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (cv != fe))
    else $error("result is neither a character nor a marker");

  // The line-end marker always closes a field and ends the run of its character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && le) |-> (fe && m_axis_tlast_o))
    else $error("line end without field end or run end");

  // Markers carry a zero character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !cv) |-> (m_axis_tdata_o == 8'h00))
    else $error("marker carries a nonzero character");

  // A stalled result stays offered unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
       && $stable(m_axis_tlast_o)))
    else $error("stalled result changed");

endmodule

bind csv_line_field_splitter_unit csvlfs_checker u_csvlfs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for csv_line_field_splitter_unit.
// Sends CSV lines one character per transfer, predicts the character and marker stream
// on its own, and checks every output transfer; depends on csvlfs_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int NumChars    = 700;
  localparam int CycleLimit  = 400000;
  localparam int HoldStart   = 400;
  localparam int HoldLength  = 300;
  localparam int DrainCycles = 8;

  typedef enum logic [2:0] {
    ModeStart,
    ModePlain,
    ModeQuoted,
    ModeQuoteSeen
  } split_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } line_char_t;

  logic                             clk_i;
  logic                             rst_ni        = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [7:0]                       s_axis_tdata  = 8'h00;
  logic                             s_axis_tlast  = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [7:0]                       m_axis_tdata;
  logic [csvlfs_pkg::UserWidth-1:0] m_axis_tuser;
  logic                             m_axis_tlast;

  line_char_t          pending_chars[$];
  logic [7:0]          line_buf[$];
  csvlfs_pkg::result_t expected_fields[$];
  split_mode_e         split_mode = ModeStart;

  int  total_chars  = 0;
  int  chars_sent   = 0;
  int  results_due  = 0;
  int  results_seen = 0;
  int  mismatches   = 0;
  int  cycles       = 0;
  int  tx_gap       = 0;
  int  rx_hold      = 0;
  int  produced;
  bit  tx_calm      = 1'b0;
  bit  rx_calm      = 1'b0;
  line_char_t next_char;
  csvlfs_pkg::result_t got, want;

  csv_line_field_splitter_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tlast_i (s_axis_tlast),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic csvlfs_pkg::result_t char_result(logic [7:0] c);
    csvlfs_pkg::result_t r;
    r = '{out_char: c, char_valid: 1'b1, field_end: 1'b0, line_end: 1'b0, run_last: 1'b0};
    return r;
  endfunction

  function automatic csvlfs_pkg::result_t marker_result(logic line);
    csvlfs_pkg::result_t r;
    r = '{out_char: 8'h00, char_valid: 1'b0, field_end: 1'b1, line_end: line, run_last: 1'b0};
    return r;
  endfunction

  // Advances the field parser by one character and queues the results it causes.
  function automatic int split_char(logic [7:0] c, logic last);
    csvlfs_pkg::result_t res[2];
    int                  n;
    split_mode_e         nxt;
    n = 0;
    if (split_mode == ModeQuoted) begin
      if (c == csvlfs_pkg::CharQuote) begin
        nxt = ModeQuoteSeen;
      end else begin
        res[n] = char_result(c);
        n++;
        nxt = ModeQuoted;
      end
    end else if (split_mode == ModeStart && c == csvlfs_pkg::CharQuote) begin
      nxt = ModeQuoted;
    end else if (split_mode == ModeQuoteSeen && c == csvlfs_pkg::CharQuote) begin
      // A doubled quote inside quotes stands for one quote.
      res[n] = char_result(c);
      n++;
      nxt = ModeQuoted;
    end else if (c == csvlfs_pkg::CharComma) begin
      res[n] = marker_result(1'b0);
      n++;
      nxt = ModeStart;
    end else begin
      res[n] = char_result(c);
      n++;
      nxt = ModePlain;
    end
    if (last) begin
      res[n] = marker_result(1'b1);
      n++;
      nxt = ModeStart;
    end
    split_mode = nxt;
    if (n > 0) res[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) expected_fields = {expected_fields, res[i]};
    return n;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == csvlfs_pkg::CharQuote || b == csvlfs_pkg::CharComma) b = b ^ 8'h01;
    return b;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  task automatic append_byte(logic [7:0] b);
    line_buf = {line_buf, b};
  endtask

  task automatic queue_line();
    line_char_t lc;
    for (int i = 0; i < line_buf.size(); i++) begin
      lc.ch   = line_buf[i];
      lc.last = (i == line_buf.size() - 1);
      pending_chars = {pending_chars, lc};
    end
    line_buf.delete();
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
    queue_line();
  endtask

  // Mostly well-formed lines with random content; the rest is noise.
  task automatic add_random_line();
    int nf;
    int len;
    int r;
    if ($urandom_range(0, 9) < 8) begin
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
        if (f > 0) append_byte(csvlfs_pkg::CharComma);
        if ($urandom_range(0, 1) == 1) begin
          append_byte(csvlfs_pkg::CharQuote);
          len = $urandom_range(0, 5);
          for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 9);
            if (r < 2) begin
              append_byte(csvlfs_pkg::CharComma);
            end else if (r < 4) begin
              append_byte(csvlfs_pkg::CharQuote);
              append_byte(csvlfs_pkg::CharQuote);
            end else begin
              append_byte(plain_byte());
            end
          end
          // Leave the last field open now and then.
          if (f != nf - 1 || $urandom_range(0, 9) != 0) begin
            append_byte(csvlfs_pkg::CharQuote);
            if ($urandom_range(0, 6) == 0) begin
              len = $urandom_range(1, 3);
              for (int i = 0; i < len; i++) begin
                append_byte(($urandom_range(0, 2) == 0) ? csvlfs_pkg::CharQuote : plain_byte());
              end
            end
          end
        end else begin
          len = $urandom_range(0, 6);
          for (int i = 0; i < len; i++) append_byte(plain_byte());
        end
      end
      if ($urandom_range(0, 9) == 0) append_byte(csvlfs_pkg::CharComma);
      if (line_buf.size() == 0) append_byte(plain_byte());
    end else begin
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 9);
        if (r < 3) append_byte(csvlfs_pkg::CharQuote);
        else if (r < 5) append_byte(csvlfs_pkg::CharComma);
        else append_byte(8'($urandom_range(0, 255)));
      end
    end
    queue_line();
  endtask

  // Sender: one transfer offered at a time, with random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        produced = split_char(s_axis_tdata, s_axis_tlast);
        chars_sent  <= chars_sent + 1;
        results_due <= results_due + produced;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_chars.size() > 0) begin
          next_char = pending_chars.pop_front();
          s_axis_tdata  <= next_char.ch;
          s_axis_tlast  <= next_char.last;
          s_axis_tvalid <= 1'b1;
          tx_gap = pick_gap(tx_calm);
          if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_hold = 0;
    end else if (cycles == HoldStart) begin
      rx_hold = HoldLength;
      m_axis_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      rx_hold = pick_gap(rx_calm);
      m_axis_tready <= (rx_hold == 0);
      if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{out_char:   m_axis_tdata,
              char_valid: m_axis_tuser[csvlfs_pkg::UserCharValid],
              field_end:  m_axis_tuser[csvlfs_pkg::UserFieldEnd],
              line_end:   m_axis_tuser[csvlfs_pkg::UserLineEnd],
              run_last:   m_axis_tlast};
      if (expected_fields.size() == 0) begin
        $error("unexpected transfer: tdata %0h, tuser %0b, tlast %0b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        want = expected_fields.pop_front();
        check_field("out_char", want.out_char, got.out_char);
        check_field("char_valid", 8'(want.char_valid), 8'(got.char_valid));
        check_field("field_end", 8'(want.field_end), 8'(got.field_end));
        check_field("line_end", 8'(want.line_end), 8'(got.line_end));
        check_field("run_last", 8'(want.run_last), 8'(got.run_last));
      end
      results_seen <= results_seen + 1;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    // Directed lines: lone opening quote at line end, quoted commas and doubled quotes
    // closed on the last character, text after a closing quote with a trailing comma,
    // an unterminated quoted field, a bare comma, and extreme byte values.
    add_text("a,\"");
    add_text("\"x,\"\"y\"");
    add_text("\"q\"z\",");
    add_text("\"ab");
    add_text(",");
    line_buf = '{8'hFF, 8'h00, csvlfs_pkg::CharQuote, csvlfs_pkg::CharComma, 8'h80};
    queue_line();
    while (pending_chars.size() < NumChars) add_random_line();
    total_chars = pending_chars.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (chars_sent != total_chars || results_seen != results_due) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_fields.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
